/* design/sas_pkg.sv */
package sas_pkg;

   localparam int DEFAULT_SET_DEPTH = 32;

   localparam logic [1:0] ACT_LOAD_A = 2'd0;
   localparam logic [1:0] ACT_LOAD_B = 2'd1;
   localparam logic [1:0] ACT_RUN    = 2'd2;
   localparam logic [1:0] ACT_CLEAR  = 2'd3;

   localparam logic [2:0] OP_INTERSECT = 3'd0;
   localparam logic [2:0] OP_A_MINUS_B = 3'd1;
   localparam logic [2:0] OP_SYM_DIFF  = 3'd2;
   localparam logic [2:0] OP_DISJOINT  = 3'd3;
   localparam logic [2:0] OP_SUPERSET  = 3'd4;
   localparam logic [2:0] OP_SUBSET    = 3'd5;
   localparam logic [2:0] OP_EQUAL     = 3'd6;

   localparam logic [1:0] KIND_ACK    = 2'd0;
   localparam logic [1:0] KIND_MEMBER = 2'd1;
   localparam logic [1:0] KIND_DONE   = 2'd2;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_DUP  = 2'd2;

   typedef struct packed {
      logic [1:0]  action;
      logic [63:0] key;
      logic [31:0] item_ref;
      logic [2:0]  operation;
      logic        proper;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] out_key;
      logic [31:0] out_ref;
      logic        from_set;
      logic        verdict;
      logic [1:0]  status;
      logic        last;
   } rsp_type;

   // Per-chain control: insert a member, rotate by one place, or empty the set.
   typedef struct packed {
      logic ins;
      logic rot;
      logic clr;
   } chain_ctl_type;

endpackage

/* design/sorted_set_algebra_engine.sv */
// Sorted-merge set engine. Each set lives in a row of cells kept in key order
// as members are loaded, so a load or a clear gives its single beat on the
// cycle after start. A run walks both rows from their heads by rotating them
// one place per step, and then rotates each row back to its first member
// before it returns to idle. Busy stays high for all of that. Result beats
// come at most one per cycle, each for one cycle only with rsp_strobe high;
// the receiver cannot stall, so it must take every beat as it comes. A run on
// a set that holds a key twice answers at once with a duplicate status and
// emits no members.
module sorted_set_algebra_engine #(
   parameter int SET_DEPTH = sas_pkg::DEFAULT_SET_DEPTH,
   localparam int CW = $clog2(SET_DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  sas_pkg::req_type req_item,
   output logic             rsp_strobe,
   output sas_pkg::rsp_type rsp_item
);

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_WALK    = 3'b010,
      ST_RESTORE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // Walk positions double as the number of rotations each row has taken.
   logic [CW-1:0] i_ff, i_in, j_ff, j_in;
   logic [2:0]    op_ff, op_in;
   logic          proper_ff, proper_in;

   // A member beat is held back until the next one is found or the walk ends, so that the final one can carry last.
   logic             pend_valid_ff, pend_valid_in;
   logic [63:0]      pend_key_ff, pend_key_in;
   logic [31:0]      pend_ref_ff, pend_ref_in;
   logic             pend_from_ff, pend_from_in;

   logic             rsp_strobe_ff, rsp_strobe_in;
   sas_pkg::rsp_type rsp_ff, rsp_in;

   sas_pkg::chain_ctl_type ctl_a, ctl_b;
   logic [63:0]   ka, kb;
   logic [31:0]   ra, rb;
   logic [CW-1:0] na, nb;
   logic          dup_a, dup_b;

   logic accept;
   logic a_has, b_has, eq, a_lt, b_lt;
   logic adv_a, adv_b, emit, emit_from, done, done_v;
   logic sup_has, sub_has, sup_lt;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   assign a_has = (i_ff < na);
   assign b_has = (j_ff < nb);
   assign eq    = (ka == kb);
   assign a_lt  = (ka < kb);
   assign b_lt  = (kb < ka);

   assign sup_has = (op_ff == sas_pkg::OP_SUPERSET) ? a_has : b_has;
   assign sub_has = (op_ff == sas_pkg::OP_SUPERSET) ? b_has : a_has;
   assign sup_lt  = (op_ff == sas_pkg::OP_SUPERSET) ? a_lt  : b_lt;

   // One step of the tandem walk.
   always_comb begin
      adv_a     = 1'b0;
      adv_b     = 1'b0;
      emit      = 1'b0;
      emit_from = 1'b0;
      done      = 1'b0;
      done_v    = 1'b0;
      case (op_ff)
         sas_pkg::OP_INTERSECT, sas_pkg::OP_A_MINUS_B, sas_pkg::OP_SYM_DIFF: begin
            if (a_has && b_has) begin
               if (eq) begin
                  adv_a = 1'b1;
                  adv_b = 1'b1;
                  emit  = (op_ff == sas_pkg::OP_INTERSECT);
               end else if (a_lt) begin
                  adv_a = 1'b1;
                  emit  = (op_ff != sas_pkg::OP_INTERSECT);
               end else begin
                  adv_b     = 1'b1;
                  emit      = (op_ff == sas_pkg::OP_SYM_DIFF);
                  emit_from = 1'b1;
               end
            end else if (a_has && op_ff != sas_pkg::OP_INTERSECT) begin
               adv_a = 1'b1;
               emit  = 1'b1;
            end else if (b_has && op_ff == sas_pkg::OP_SYM_DIFF) begin
               adv_b     = 1'b1;
               emit      = 1'b1;
               emit_from = 1'b1;
            end else begin
               done = 1'b1;
            end
         end
         sas_pkg::OP_DISJOINT: begin
            if (a_has && b_has) begin
               if (eq) begin
                  done = 1'b1;
               end else if (a_lt) begin
                  adv_a = 1'b1;
               end else begin
                  adv_b = 1'b1;
               end
            end else begin
               done   = 1'b1;
               done_v = 1'b1;
            end
         end
         sas_pkg::OP_SUPERSET, sas_pkg::OP_SUBSET: begin
            if (!sub_has) begin
               done   = 1'b1;
               done_v = !(proper_ff && na == nb);
            end else if (!sup_has) begin
               done = 1'b1;
            end else if (sup_lt) begin
               adv_a = (op_ff == sas_pkg::OP_SUPERSET);
               adv_b = (op_ff == sas_pkg::OP_SUBSET);
            end else if (eq) begin
               adv_a = 1'b1;
               adv_b = 1'b1;
            end else begin
               done = 1'b1;
            end
         end
         sas_pkg::OP_EQUAL: begin
            if (na != nb) begin
               done = 1'b1;
            end else if (a_has && b_has) begin
               if (eq) begin
                  adv_a = 1'b1;
                  adv_b = 1'b1;
               end else begin
                  done = 1'b1;
               end
            end else begin
               done   = 1'b1;
               done_v = 1'b1;
            end
         end
         default: begin
            done = 1'b1;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      op_in         = op_ff;
      proper_in     = proper_ff;
      pend_valid_in = pend_valid_ff;
      pend_key_in   = pend_key_ff;
      pend_ref_in   = pend_ref_ff;
      pend_from_in  = pend_from_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      ctl_a         = '0;
      ctl_b         = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_item.action)
                  sas_pkg::ACT_LOAD_A, sas_pkg::ACT_LOAD_B: begin
                     rsp_strobe_in    = 1'b1;
                     rsp_in.kind      = sas_pkg::KIND_ACK;
                     rsp_in.out_key   = req_item.key;
                     rsp_in.out_ref   = req_item.item_ref;
                     rsp_in.from_set  = req_item.action[0];
                     rsp_in.last      = 1'b1;
                     if (req_item.action == sas_pkg::ACT_LOAD_A) begin
                        if (na == CW'(SET_DEPTH)) begin
                           rsp_in.status = sas_pkg::STATUS_FULL;
                        end else begin
                           ctl_a.ins = 1'b1;
                        end
                     end else begin
                        if (nb == CW'(SET_DEPTH)) begin
                           rsp_in.status = sas_pkg::STATUS_FULL;
                        end else begin
                           ctl_b.ins = 1'b1;
                        end
                     end
                  end
                  sas_pkg::ACT_RUN: begin
                     if (dup_a || dup_b) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.kind   = sas_pkg::KIND_DONE;
                        rsp_in.status = sas_pkg::STATUS_DUP;
                        rsp_in.last   = 1'b1;
                     end else begin
                        state_in      = ST_WALK;
                        i_in          = '0;
                        j_in          = '0;
                        op_in         = req_item.operation;
                        proper_in     = req_item.proper;
                        pend_valid_in = 1'b0;
                     end
                  end
                  default: begin
                     ctl_a.clr     = 1'b1;
                     ctl_b.clr     = 1'b1;
                     rsp_strobe_in = 1'b1;
                     rsp_in.kind   = sas_pkg::KIND_DONE;
                     rsp_in.last   = 1'b1;
                  end
               endcase
            end
         end
         ST_WALK: begin
            ctl_a.rot = adv_a;
            ctl_b.rot = adv_b;
            if (adv_a) begin
               i_in = i_ff + CW'(1);
            end
            if (adv_b) begin
               j_in = j_ff + CW'(1);
            end
            if (done) begin
               state_in      = ST_RESTORE;
               rsp_strobe_in = 1'b1;
               rsp_in.last   = 1'b1;
               if (pend_valid_ff) begin
                  rsp_in.kind     = sas_pkg::KIND_MEMBER;
                  rsp_in.out_key  = pend_key_ff;
                  rsp_in.out_ref  = pend_ref_ff;
                  rsp_in.from_set = pend_from_ff;
               end else begin
                  rsp_in.kind    = sas_pkg::KIND_DONE;
                  rsp_in.verdict = done_v;
               end
            end else if (emit) begin
               if (pend_valid_ff) begin
                  rsp_strobe_in   = 1'b1;
                  rsp_in.kind     = sas_pkg::KIND_MEMBER;
                  rsp_in.out_key  = pend_key_ff;
                  rsp_in.out_ref  = pend_ref_ff;
                  rsp_in.from_set = pend_from_ff;
               end
               pend_valid_in = 1'b1;
               pend_from_in  = emit_from;
               pend_key_in   = emit_from ? kb : ka;
               pend_ref_in   = emit_from ? rb : ra;
            end
         end
         ST_RESTORE: begin
            // Finish a full turn of each row so the next run starts at the head.
            ctl_a.rot = a_has;
            ctl_b.rot = b_has;
            if (a_has) begin
               i_in = i_ff + CW'(1);
            end
            if (b_has) begin
               j_in = j_ff + CW'(1);
            end
            if (!a_has && !b_has) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      j_ff         <= j_in;
      op_ff        <= op_in;
      proper_ff    <= proper_in;
      pend_key_ff  <= pend_key_in;
      pend_ref_ff  <= pend_ref_in;
      pend_from_ff <= pend_from_in;
      rsp_ff       <= rsp_in;
   end

   sas_chain #(.SET_DEPTH(SET_DEPTH)) u_chain_a (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl_a),
      .new_key  (req_item.key),
      .new_ref  (req_item.item_ref),
      .head_key (ka),
      .head_ref (ra),
      .count    (na),
      .dup      (dup_a)
   );

   sas_chain #(.SET_DEPTH(SET_DEPTH)) u_chain_b (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl_b),
      .new_key  (req_item.key),
      .new_ref  (req_item.item_ref),
      .head_key (kb),
      .head_ref (rb),
      .count    (nb),
      .dup      (dup_b)
   );

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

/* design/sas_cell.sv */
// One place of a sorted chain. Insertion shifts larger keys one place up;
// rotation moves every member one place down, the head wrapping to the tail.
module sas_cell (
   input  logic                   clock,
   input  sas_pkg::chain_ctl_type ctl,
   input  logic                   valid,
   input  logic                   wrap,
   input  logic [63:0]            new_key,
   input  logic [63:0]            prev_key,
   input  logic [31:0]            prev_ref,
   input  logic                   prev_le,
   input  logic [63:0]            next_key,
   input  logic [31:0]            next_ref,
   input  logic [63:0]            head_key,
   input  logic [31:0]            head_ref,
   input  logic [31:0]            new_ref,
   output logic [63:0]            key,
   output logic [31:0]            item_ref,
   output logic                   le,
   output logic                   eq
);

   logic [63:0] key_ff, key_in;
   logic [31:0] ref_ff, ref_in;

   assign le       = valid && (key_ff <= new_key);
   assign eq       = valid && (key_ff == new_key);
   assign key      = key_ff;
   assign item_ref = ref_ff;

   always_comb begin
      key_in = key_ff;
      ref_in = ref_ff;
      if (ctl.ins) begin
         if (!le) begin
            if (prev_le) begin
               key_in = new_key;
               ref_in = new_ref;
            end else begin
               key_in = prev_key;
               ref_in = prev_ref;
            end
         end
      end else if (ctl.rot) begin
         if (wrap) begin
            key_in = head_key;
            ref_in = head_ref;
         end else begin
            key_in = next_key;
            ref_in = next_ref;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      ref_ff <= ref_in;
   end

endmodule

/* design/sas_chain.sv */
// A set held as a row of cells kept in ascending key order.
module sas_chain #(
   parameter int SET_DEPTH = sas_pkg::DEFAULT_SET_DEPTH,
   localparam int CW = $clog2(SET_DEPTH + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sas_pkg::chain_ctl_type ctl,
   input  logic [63:0]            new_key,
   input  logic [31:0]            new_ref,
   output logic [63:0]            head_key,
   output logic [31:0]            head_ref,
   output logic [CW-1:0]          count,
   output logic                   dup
);

   logic [CW-1:0] count_ff, count_in;
   logic          dup_ff, dup_in;
   logic [63:0]   keys [SET_DEPTH];
   logic [31:0]   refs [SET_DEPTH];
   logic [SET_DEPTH-1:0] le_vec, eq_vec;

   for (genvar k = 0; k < SET_DEPTH; k++) begin : g_cell
      localparam logic [CW-1:0] IDX  = CW'(k);
      localparam logic [CW-1:0] IDX1 = CW'(k + 1);
      logic [63:0] pk, nk;
      logic [31:0] pr, nr;
      logic        pl;
      if (k == 0) begin : g_first
         assign pk = new_key;
         assign pr = new_ref;
         assign pl = 1'b0;
      end else begin : g_mid
         assign pk = keys[k-1];
         assign pr = refs[k-1];
         assign pl = le_vec[k-1];
      end
      if (k == SET_DEPTH - 1) begin : g_last
         assign nk = keys[0];
         assign nr = refs[0];
      end else begin : g_inner
         assign nk = keys[k+1];
         assign nr = refs[k+1];
      end
      sas_cell u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .valid    (count_ff > IDX),
         .wrap     (count_ff == IDX1),
         .new_key  (new_key),
         .prev_key (pk),
         .prev_ref (pr),
         .prev_le  (pl),
         .next_key (nk),
         .next_ref (nr),
         .head_key (keys[0]),
         .head_ref (refs[0]),
         .new_ref  (new_ref),
         .key      (keys[k]),
         .item_ref (refs[k]),
         .le       (le_vec[k]),
         .eq       (eq_vec[k])
      );
   end

   always_comb begin
      count_in = count_ff;
      dup_in   = dup_ff;
      if (ctl.clr) begin
         count_in = '0;
         dup_in   = 1'b0;
      end else if (ctl.ins) begin
         count_in = count_ff + CW'(1);
         dup_in   = dup_ff | (|eq_vec);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         dup_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         dup_ff   <= dup_in;
      end
   end

   assign head_key = keys[0];
   assign head_ref = refs[0];
   assign count    = count_ff;
   assign dup      = dup_ff;

endmodule

/* design/sas_check.sv */
module sas_check (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input sas_pkg::req_type req_item,
   input logic             rsp_strobe,
   input sas_pkg::rsp_type rsp_item
);

   logic accept;
   assign accept = start && !busy;

   a_load_ack: assert property (@(posedge clock) disable iff (reset)
      accept && (req_item.action == sas_pkg::ACT_LOAD_A ||
                 req_item.action == sas_pkg::ACT_LOAD_B)
      |=> rsp_strobe && rsp_item.kind == sas_pkg::KIND_ACK && rsp_item.last)
      else $error("load without acknowledge");

   a_clear_done: assert property (@(posedge clock) disable iff (reset)
      accept && req_item.action == sas_pkg::ACT_CLEAR
      |=> rsp_strobe && rsp_item.kind == sas_pkg::KIND_DONE &&
          rsp_item.status == sas_pkg::STATUS_OK)
      else $error("clear without finished beat");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.kind == sas_pkg::KIND_DONE |-> rsp_item.last)
      else $error("verdict beat without last");

   a_member_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.kind == sas_pkg::KIND_MEMBER
      |-> !rsp_item.verdict && rsp_item.status == sas_pkg::STATUS_OK)
      else $error("member beat with verdict or status");

endmodule

bind sorted_set_algebra_engine sas_check u_sas_check (.*);
